// ===== hw/rtl/lsfcd_pkg.sv =====
package lsfcd_pkg;

    localparam int W_BYTE   = 8;
    localparam int W_STATUS = 2;
    localparam int W_COUNT  = 12;
    localparam int W_RANGE  = 2;
    localparam int W_LUX    = 30;
    localparam int W_BASE   = 18;

    localparam logic [W_BYTE-1:0] CRC_POLY = 8'h31;
    localparam logic [W_BYTE-1:0] CRC_INIT = 8'h00;

    // 4096 * 250000 / 4096 -> count * 250000 is lux times 4096
    localparam logic [W_BASE-1:0] LUX_NUM = 18'd250000;

    // range codes from bits 3..2 of the second byte
    localparam logic [W_RANGE-1:0] RC_INVALID = 2'd0;
    localparam logic [W_RANGE-1:0] RC_DIV1    = 2'd1;
    localparam logic [W_RANGE-1:0] RC_DIV4    = 2'd2;
    localparam logic [W_RANGE-1:0] RC_DIV16   = 2'd3;

    typedef enum logic [W_STATUS-1:0] {
        ST_OK        = 2'd0,
        ST_CRC_ERR   = 2'd1,
        ST_RANGE_ERR = 2'd2
    } t_status;

    // byte expected next within the frame
    typedef enum logic [2:0] {
        POS_0 = 3'b001,
        POS_1 = 3'b010,
        POS_2 = 3'b100
    } t_pos;

    typedef struct packed {
        t_status              status;
        logic [W_COUNT-1:0]   raw_count;
        logic [W_RANGE-1:0]   range_code;
        logic [W_LUX-1:0]     lux_scaled;
    } t_result;

    // crc-8, msb first, no final xor
    function automatic logic [W_BYTE-1:0] crc8_update(
        input logic [W_BYTE-1:0] crc,
        input logic [W_BYTE-1:0] data
    );
        logic [W_BYTE-1:0] c;
        c = crc ^ data;
        for (int k = 0; k < W_BYTE; k++) begin
            if (c[W_BYTE-1]) begin
                c = {c[W_BYTE-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[W_BYTE-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/lsfcd_in_if.sv =====
interface lsfcd_in_if import lsfcd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [W_BYTE-1:0] frame_byte;
    logic              frame_start;

    modport source (output valid, output frame_byte, output frame_start, input ready);
    modport sink   (input valid, input frame_byte, input frame_start, output ready);
endinterface

// ===== hw/rtl/lsfcd_out_if.sv =====
interface lsfcd_out_if import lsfcd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [W_STATUS-1:0] status;
    logic [W_COUNT-1:0]  raw_count;
    logic [W_RANGE-1:0]  range_code;
    logic [W_LUX-1:0]    lux_scaled;

    modport source (output valid, output status, output raw_count, output range_code,
                    output lux_scaled, input ready);
    modport sink   (input valid, input status, input raw_count, input range_code,
                    input lux_scaled, output ready);
endinterface

// ===== hw/rtl/lsfcd_frame_decode.sv =====
module lsfcd_frame_decode import lsfcd_pkg::*; (
    input  logic [W_BYTE-1:0] i_high_byte,
    input  logic [W_BYTE-1:0] i_low_byte,
    input  logic [W_BYTE-1:0] i_crc,
    input  logic [W_BYTE-1:0] i_check_byte,
    output t_result           o_result
);

    logic [W_COUNT-1:0] w_count;
    logic [W_RANGE-1:0] w_range;
    logic [W_BASE-1:0]  w_base;
    logic [W_LUX-1:0]   w_product;

    assign w_count = {i_high_byte, i_low_byte[7:4]};
    assign w_range = i_low_byte[3:2];

    // exact divide by 1, 4 or 16 folded into the constant
    always_comb begin
        unique case (w_range)
            RC_DIV1:  w_base = LUX_NUM;
            RC_DIV4:  w_base = LUX_NUM >> 2;
            RC_DIV16: w_base = LUX_NUM >> 4;
            default:  w_base = '0;
        endcase
    end

    // 12 x 18 product, max value fits 30 bits
    assign w_product = W_LUX'(W_LUX'(w_count) * W_LUX'(w_base));

    always_comb begin
        o_result.raw_count  = w_count;
        o_result.range_code = w_range;
        priority if (i_crc != i_check_byte) begin
            o_result.status     = ST_CRC_ERR;
            o_result.lux_scaled = '0;
        end else if (w_range == RC_INVALID) begin
            o_result.status     = ST_RANGE_ERR;
            o_result.lux_scaled = '0;
        end else begin
            o_result.status     = ST_OK;
            o_result.lux_scaled = w_product;
        end
    end

endmodule

// ===== hw/rtl/light_sensor_frame_check_decode.sv =====
// the crc update and 12x18 multiply are combinational; a frame result is
//   registered as its third byte leaves the input stage; one byte per cycle
//   unless a third byte waits on a full result register the sink has not taken
// reset (i_rst_n low, synchronous): both stages empty, frame alignment back to
//   the first byte, crc and captured bytes cleared
module light_sensor_frame_check_decode import lsfcd_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    lsfcd_in_if.sink        i_item,
    lsfcd_out_if.source     o_item
);

    // input stage: one captured byte waiting to be processed
    logic              r_s1_valid;
    logic [W_BYTE-1:0] r_s1_byte;
    logic              r_s1_start;

    // frame state
    t_pos              r_pos;
    t_pos              n_pos;
    logic [W_BYTE-1:0] r_crc;
    logic [W_BYTE-1:0] n_crc;
    logic [W_BYTE-1:0] r_high;
    logic [W_BYTE-1:0] r_low;

    // result register
    logic              r_out_valid;
    t_result           r_out;

    t_pos              w_pos_eff;
    logic              w_emit;
    logic              w_s1_go;
    logic              w_in_accept;
    t_result           w_result;

    // a start flag forces the byte to be the first of a new frame
    assign w_pos_eff = r_s1_start ? POS_0 : r_pos;
    assign w_emit    = (w_pos_eff == POS_2);

    // bytes that give no result always drain; the third byte needs room in
    // the result register, which frees up when the sink takes it
    assign w_s1_go     = r_s1_valid && (!w_emit || !r_out_valid || o_item.ready);
    assign w_in_accept = i_item.valid && i_item.ready;

    assign i_item.ready = !r_s1_valid || w_s1_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_s1_byte  <= i_item.frame_byte;
            r_s1_start <= i_item.frame_start;
        end
    end

    // next frame state for the byte in the input stage
    always_comb begin
        unique case (w_pos_eff)
            POS_0: begin
                n_pos = POS_1;
                n_crc = crc8_update(CRC_INIT, r_s1_byte);
            end
            POS_1: begin
                n_pos = POS_2;
                n_crc = crc8_update(r_crc, r_s1_byte);
            end
            POS_2: begin
                // frame complete, wrap to the first byte
                n_pos = POS_0;
                n_crc = CRC_INIT;
            end
            default: begin
                n_pos = POS_0;
                n_crc = CRC_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= POS_0;
            r_crc  <= CRC_INIT;
            r_high <= '0;
            r_low  <= '0;
        end else if (w_s1_go) begin
            r_pos <= n_pos;
            r_crc <= n_crc;
            if (w_pos_eff == POS_0) begin
                r_high <= r_s1_byte;
            end
            if (w_pos_eff == POS_1) begin
                r_low <= r_s1_byte;
            end
        end
    end

    // third byte: crc check, field split and lux scaling
    lsfcd_frame_decode u_decode (
        .i_high_byte  (r_high),
        .i_low_byte   (r_low),
        .i_crc        (r_crc),
        .i_check_byte (r_s1_byte),
        .o_result     (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_go && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_item.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_go && w_emit) begin
            r_out <= w_result;
        end
    end

    assign o_item.valid      = r_out_valid;
    assign o_item.status     = r_out.status;
    assign o_item.raw_count  = r_out.raw_count;
    assign o_item.range_code = r_out.range_code;
    assign o_item.lux_scaled = r_out.lux_scaled;

    // a failed frame never carries a lux value
    a_lux_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_item.valid && (o_item.status != ST_OK) |-> (o_item.lux_scaled == '0))
        else $error("lux nonzero on failed frame");

    // a held byte is not dropped while the result register is blocked
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !w_s1_go |=> r_s1_valid)
        else $error("input stage byte lost");

    // a completed frame lands in the result register
    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_go && w_emit |=> r_out_valid)
        else $error("frame result not registered");

    // after a third byte the next byte is taken as the first of a frame
    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_go && w_emit |=> (r_pos == POS_0) && (r_crc == CRC_INIT))
        else $error("frame alignment not restarted");

endmodule

// ===== bench/light_sensor_frame_check_decode_tb.sv =====
module light_sensor_frame_check_decode_tb;
    import lsfcd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // idle patterns applied by the driver and the receiver
    typedef enum int {
        PH_FREE,
        PH_SRC_IDLE,
        PH_SNK_STALL,
        PH_BOTH
    } t_phase;

    typedef struct {
        logic [W_BYTE-1:0] data;
        logic              start;
    } t_frame_byte;

    localparam int RANDOM_ITEMS = 900;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int TAIL_CYCLES  = 10;

    logic clk;
    logic rst_n;

    lsfcd_in_if  in_if ();
    lsfcd_out_if out_if ();

    light_sensor_frame_check_decode dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_item  (in_if),
        .o_item  (out_if)
    );

    // bytes waiting to be driven and decoded frames waiting to come out
    t_frame_byte byte_queue[$];
    t_result     pending_results[$];

    t_phase phase;
    bit     in_busy;
    int     n_errors;
    int     n_pushed;

    // decoder state kept by the bench
    t_pos              frame_pos;
    logic [W_BYTE-1:0] frame_crc;
    logic [W_BYTE-1:0] hi_byte;
    logic [W_BYTE-1:0] lo_byte;

    // 10 ns clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // bitwise crc-8 step, one data bit at a time against the top crc bit
    function automatic logic [W_BYTE-1:0] crc_next(
        input logic [W_BYTE-1:0] crc,
        input logic [W_BYTE-1:0] data
    );
        logic [W_BYTE-1:0] c;
        logic              fb;
        c = crc;
        for (int i = W_BYTE - 1; i >= 0; i--) begin
            fb = c[W_BYTE-1] ^ data[i];
            c  = {c[W_BYTE-2:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    // fold one accepted byte into the bench state, queue a result on byte 2
    task automatic decode_byte(input logic [W_BYTE-1:0] data, input logic start);
        t_result           res;
        logic [W_COUNT-1:0] count;
        logic [W_RANGE-1:0] rc;
        logic [31:0]        base;
        t_pos               pos;
        pos = start ? POS_0 : frame_pos;
        case (pos)
            POS_1: begin
                lo_byte   = data;
                frame_crc = crc_next(frame_crc, data);
                frame_pos = POS_2;
            end
            POS_2: begin
                count = {hi_byte, lo_byte[7:4]};
                rc    = lo_byte[3:2];
                res.raw_count  = count;
                res.range_code = rc;
                res.lux_scaled = '0;
                if (frame_crc != data) begin
                    // crc check wins over the range check
                    res.status = ST_CRC_ERR;
                end else if (rc == RC_INVALID) begin
                    res.status = ST_RANGE_ERR;
                end else begin
                    res.status = ST_OK;
                    case (rc)
                        RC_DIV1: base = 32'(LUX_NUM);
                        RC_DIV4: base = 32'(LUX_NUM) >> 2;
                        default: base = 32'(LUX_NUM) >> 4;
                    endcase
                    res.lux_scaled = W_LUX'(32'(count) * base);
                end
                pending_results.push_back(res);
                frame_pos = POS_0;
                frame_crc = CRC_INIT;
            end
            default: begin
                // first byte, also taken when start realigns mid-frame
                hi_byte   = data;
                frame_crc = crc_next(CRC_INIT, data);
                frame_pos = POS_1;
            end
        endcase
    endtask

    task automatic push_byte(input logic [W_BYTE-1:0] data, input logic start);
        t_frame_byte fb;
        fb.data  = data;
        fb.start = start;
        byte_queue.push_back(fb);
        n_pushed++;
    endtask

    // whole frame; a bad crc gets a nonzero xor on the check byte
    task automatic push_frame(
        input logic [W_COUNT-1:0] count,
        input logic [W_RANGE-1:0] rc,
        input logic [1:0]         spare,
        input logic               start,
        input bit                 crc_ok
    );
        logic [W_BYTE-1:0] b0;
        logic [W_BYTE-1:0] b1;
        logic [W_BYTE-1:0] chk;
        logic [W_BYTE-1:0] flip;
        b0  = count[11:4];
        b1  = {count[3:0], rc, spare};
        chk = crc_next(crc_next(CRC_INIT, b0), b1);
        if (!crc_ok) begin
            flip = W_BYTE'($urandom_range(255, 1));
            chk  = chk ^ flip;
        end
        push_byte(b0, start);
        push_byte(b1, 1'b0);
        push_byte(chk, 1'b0);
    endtask

    function automatic bit src_send();
        if (phase == PH_SRC_IDLE) return $urandom_range(99) >= 74;
        if (phase == PH_BOTH)     return $urandom_range(99) >= 20;
        return 1'b1;
    endfunction

    function automatic bit snk_take();
        if (phase == PH_SNK_STALL) return $urandom_range(99) >= 74;
        if (phase == PH_BOTH)      return $urandom_range(99) >= 20;
        return 1'b1;
    endfunction

    // driver: all inputs move on the falling edge
    always @(negedge clk) begin
        t_frame_byte fb;
        if (!rst_n) begin
            in_if.valid  <= 1'b0;
            out_if.ready <= 1'b0;
        end else begin
            if (!in_busy) begin
                if (byte_queue.size() > 0 && src_send()) begin
                    fb = byte_queue.pop_front();
                    in_if.valid       <= 1'b1;
                    in_if.frame_byte  <= fb.data;
                    in_if.frame_start <= fb.start;
                    in_busy = 1'b1;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
            out_if.ready <= snk_take();
        end
    end

    // monitor: handshakes sampled on the rising edge
    always @(posedge clk) begin
        t_result want;
        if (rst_n) begin
            if (in_if.valid && in_if.ready) begin
                decode_byte(in_if.frame_byte, in_if.frame_start);
                in_busy = 1'b0;
            end
            if (out_if.valid && out_if.ready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result item: status %0d count %0d range %0d lux %0d",
                           out_if.status, out_if.raw_count, out_if.range_code,
                           out_if.lux_scaled);
                    n_errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (out_if.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, out_if.status);
                        n_errors++;
                    end
                    if (out_if.raw_count !== want.raw_count) begin
                        $error("raw_count: expected %0d, actual %0d",
                               want.raw_count, out_if.raw_count);
                        n_errors++;
                    end
                    if (out_if.range_code !== want.range_code) begin
                        $error("range_code: expected %0d, actual %0d",
                               want.range_code, out_if.range_code);
                        n_errors++;
                    end
                    if (out_if.lux_scaled !== want.lux_scaled) begin
                        $error("lux_scaled: expected %0d, actual %0d",
                               want.lux_scaled, out_if.lux_scaled);
                        n_errors++;
                    end
                end
            end
        end
    end

    // random frames and the noise around them for one idle phase
    task automatic random_stretch(input t_phase ph, input int n_items);
        int stop_at;
        int pick;
        stop_at = n_pushed + n_items;
        phase = ph;
        while (n_pushed < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
                // well-formed frame, mostly good crc
                push_frame(W_COUNT'($urandom), W_RANGE'($urandom), 2'($urandom), 1'b1,
                           $urandom_range(9) != 0);
            end else if (pick < 75) begin
                // no start flag, relies on wrap after the previous frame
                push_frame(W_COUNT'($urandom), W_RANGE'($urandom), 2'($urandom), 1'b0,
                           $urandom_range(3) != 0);
            end else if (pick < 87) begin
                // broken frame: one or two bytes, then a fresh start
                push_byte(W_BYTE'($urandom), 1'b1);
                if ($urandom_range(1)) begin
                    push_byte(W_BYTE'($urandom), 1'b0);
                end
                push_frame(W_COUNT'($urandom), W_RANGE'($urandom), 2'($urandom), 1'b1,
                           1'b1);
            end else begin
                // raw noise with a random start flag
                push_byte(W_BYTE'($urandom), 1'($urandom));
            end
        end
        while (byte_queue.size() > 0 || in_busy) @(posedge clk);
    endtask

    // run limit
    initial begin
        #3000000;
        $display("status: fail");
        $finish;
    end

    initial begin
        int waited;
        in_if.valid       = 1'b0;
        in_if.frame_byte  = '0;
        in_if.frame_start = 1'b0;
        out_if.ready      = 1'b0;
        in_busy   = 1'b0;
        n_errors  = 0;
        n_pushed  = 0;
        phase     = PH_FREE;
        frame_pos = POS_0;
        frame_crc = CRC_INIT;
        hi_byte   = '0;
        lo_byte   = '0;

        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes, every range code, crc precedence
        push_frame(12'd0,    RC_DIV1,    2'b00, 1'b1, 1'b1);
        push_frame(12'hfff,  RC_DIV1,    2'b11, 1'b1, 1'b1);
        push_frame(12'hfff,  RC_DIV4,    2'b11, 1'b1, 1'b1);
        push_frame(12'hfff,  RC_DIV16,   2'b11, 1'b1, 1'b1);
        push_frame(12'h5a5,  RC_INVALID, 2'b10, 1'b1, 1'b1);
        push_frame(12'h3c3,  RC_INVALID, 2'b01, 1'b1, 1'b0);
        push_frame(12'h123,  RC_DIV16,   2'b00, 1'b1, 1'b0);
        // start flag after one byte, then after two bytes
        push_byte(8'hff, 1'b1);
        push_frame(12'h800,  RC_DIV4,    2'b01, 1'b1, 1'b1);
        push_byte(8'h00, 1'b1);
        push_byte(8'hff, 1'b0);
        push_frame(12'h001,  RC_DIV1,    2'b10, 1'b1, 1'b1);
        // a frame with no start flag right after the last one, wrapping alignment
        push_frame(12'hfff,  RC_DIV16,   2'b00, 1'b0, 1'b1);
        while (byte_queue.size() > 0 || in_busy) @(posedge clk);

        random_stretch(PH_FREE,      RANDOM_ITEMS / 5);
        random_stretch(PH_SRC_IDLE,  RANDOM_ITEMS / 5);
        random_stretch(PH_SNK_STALL, RANDOM_ITEMS / 5);
        random_stretch(PH_BOTH,      RANDOM_ITEMS / 5);
        random_stretch(PH_FREE,      RANDOM_ITEMS / 5);

        // drain the remaining results, with a bound
        waited = 0;
        while (pending_results.size() > 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        if (pending_results.size() > 0) begin
            $error("%0d result items never arrived", pending_results.size());
            n_errors++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (n_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
